>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the RTL: clocked checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define CHECK_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on every rising clk edge outside reset
`define CHECK_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication checked on every rising clk edge outside reset
`define CHECK_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/rmmd_pkg.sv
// ----------------------------------------------------------------------------
// rmmd_pkg
// Types and constants of the row minimum median depth block.
// ----------------------------------------------------------------------------
package rmmd_pkg;

	localparam int MAX_ROWS        = 256;
	localparam int DEPTH_FRAC_BITS = 16;
	localparam int DEPTH_W         = 32;
	localparam int MED_W           = 33;
	localparam int SEEN_W          = 9;
	localparam int DEPTH_SCALE     = 100000;
	localparam int SCALE_W         = 17;
	localparam int PROD_W          = DEPTH_W + SCALE_W;
	localparam int IDX_W           = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNT_W           = $clog2(MAX_ROWS + 1);
	localparam int CNTX_W          = (CNT_W > SEEN_W) ? CNT_W : SEEN_W;
	localparam int GRP_SIZE        = 16;
	localparam int NUM_GRP         = (MAX_ROWS + GRP_SIZE - 1) / GRP_SIZE;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth_sample;
		logic               row_last;
		logic               box_last;
	} rmmd_in_t;

	typedef struct packed {
		logic [MED_W-1:0]  median_depth;
		logic [SEEN_W-1:0] rows_seen;
		logic              empty_box;
		logic              rows_overflow;
	} rmmd_out_t;

	// what one cell hands to its right neighbor
	typedef struct packed {
		logic [DEPTH_W-1:0] value;
		logic               occ;
		logic               gt;
	} rmmd_link_t;

endpackage

>>> rtl/rmmd_cell.sv
// ----------------------------------------------------------------------------
// rmmd_cell
// One slot of the sorted row minimum chain: takes the new minimum or its left
// neighbor's value so that the chain stays in ascending order.
// ----------------------------------------------------------------------------
module rmmd_cell (
	input  logic                          clk,
	input  logic                          ins,
	input  logic [rmmd_pkg::DEPTH_W-1:0]  new_val,
	input  logic                          occ,
	input  rmmd_pkg::rmmd_link_t          left,
	output rmmd_pkg::rmmd_link_t          link
);

	logic [rmmd_pkg::DEPTH_W-1:0] val_q;
	logic                         gt;
	logic                         take;

	assign gt   = occ & (val_q > new_val);
	assign take = ins & ((occ & gt) | (!occ & left.occ));

	always_ff @(posedge clk) begin
		if (take) begin
			val_q <= left.gt ? left.value : new_val;
		end
	end

	assign link.value = val_q;
	assign link.occ   = occ;
	assign link.gt    = gt;

endmodule

>>> rtl/row_minimum_median_depth.sv
// ----------------------------------------------------------------------------
// row_minimum_median_depth
// Median of the row minima of a depth bounding box, scaled by 100000.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle in raster order unless pixel_stall is high.
// Each completed row minimum is inserted, while there is room, into a chain
// of MAX_ROWS sorting cells. After the pixel with box_last the input stalls
// while the median is picked from the chain through a two-level select and
// scaled by one multiplier; it stays stalled while the previous result is held.
// ----------------------------------------------------------------------------
module row_minimum_median_depth (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pixel_valid,
	output logic                pixel_stall,
	input  rmmd_pkg::rmmd_in_t  pixel,
	output logic                result_valid,
	input  logic                result_stall,
	output rmmd_pkg::rmmd_out_t result
);

	logic [rmmd_pkg::DEPTH_W-1:0] row_min_q;
	logic                         row_started_q;
	logic [rmmd_pkg::CNT_W-1:0]   count_q;
	logic                         ovf_q;

	logic                         pix_acc;
	logic [rmmd_pkg::DEPTH_W-1:0] cur_min;
	logic                         full;
	logic                         ins;

	logic                         valid_s1;
	logic [rmmd_pkg::CNT_W-1:0]   cnt_s1;
	logic                         ovf_s1;
	logic [rmmd_pkg::IDX_W-1:0]   mid_s1;

	logic                         valid_s2;
	logic [rmmd_pkg::CNT_W-1:0]   cnt_s2;
	logic                         ovf_s2;
	logic [rmmd_pkg::DEPTH_W-1:0] grp_s2 [rmmd_pkg::NUM_GRP];

	logic                         valid_s3;
	logic [rmmd_pkg::CNT_W-1:0]   cnt_s3;
	logic                         ovf_s3;
	logic [rmmd_pkg::DEPTH_W-1:0] med_s3;

	logic                         result_valid_q;
	rmmd_pkg::rmmd_out_t          result_q;
	logic                         out_adv;

	rmmd_pkg::rmmd_link_t         links [rmmd_pkg::MAX_ROWS];
	logic [rmmd_pkg::MAX_ROWS-1:0] pick;
	logic [rmmd_pkg::DEPTH_W-1:0] grp_d [rmmd_pkg::NUM_GRP];
	logic [rmmd_pkg::DEPTH_W-1:0] med_d;

	logic [rmmd_pkg::PROD_W-1:0]  prod;
	logic [rmmd_pkg::PROD_W-1:0]  scaled;
	logic [rmmd_pkg::CNTX_W-1:0]  cnt_ext;
	rmmd_pkg::rmmd_out_t          out_d;

	assign pixel_stall = valid_s1 | valid_s2 | valid_s3;
	assign pix_acc     = pixel_valid & !pixel_stall;
	assign cur_min     = (!row_started_q || (pixel.depth_sample < row_min_q)) ?
		pixel.depth_sample : row_min_q;
	assign full        = (count_q >= rmmd_pkg::CNT_W'(rmmd_pkg::MAX_ROWS));
	assign ins         = pix_acc & pixel.row_last & !full;
	assign mid_s1      = rmmd_pkg::IDX_W'(cnt_s1 >> 1);
	assign out_adv     = !result_valid_q | !result_stall;

	// sorting cell chain
	for (genvar i = 0; i < rmmd_pkg::MAX_ROWS; i++) begin : g_cell
		rmmd_pkg::rmmd_link_t left;
		logic                 occ;

		assign occ     = (count_q > rmmd_pkg::CNT_W'(i));
		assign pick[i] = (rmmd_pkg::IDX_W'(i) == mid_s1);

		if (i == 0) begin : g_head
			assign left = '{value: '0, occ: 1'b1, gt: 1'b0};
		end else begin : g_body
			assign left = links[i-1];
		end

		rmmd_cell u_cell (
			.clk     (clk),
			.ins     (ins),
			.new_val (cur_min),
			.occ     (occ),
			.left    (left),
			.link    (links[i])
		);
	end

	// first level of the median select
	always_comb begin
		for (int g = 0; g < rmmd_pkg::NUM_GRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < rmmd_pkg::GRP_SIZE; k++) begin
				if ((g * rmmd_pkg::GRP_SIZE + k) < rmmd_pkg::MAX_ROWS) begin
					if (pick[g * rmmd_pkg::GRP_SIZE + k]) begin
						grp_d[g] = grp_d[g] | links[g * rmmd_pkg::GRP_SIZE + k].value;
					end
				end
			end
		end
	end

	// second level of the median select
	always_comb begin
		med_d = '0;
		for (int g = 0; g < rmmd_pkg::NUM_GRP; g++) begin
			med_d = med_d | grp_s2[g];
		end
	end

	// scaling and saturation
	always_comb begin
		prod    = rmmd_pkg::PROD_W'(med_s3) * rmmd_pkg::PROD_W'(rmmd_pkg::DEPTH_SCALE);
		scaled  = prod >> rmmd_pkg::DEPTH_FRAC_BITS;
		cnt_ext = rmmd_pkg::CNTX_W'(cnt_s3);
		out_d   = '0;
		out_d.rows_overflow = ovf_s3;
		if (cnt_s3 == '0) begin
			out_d.empty_box = 1'b1;
		end else begin
			if (scaled > rmmd_pkg::PROD_W'({rmmd_pkg::MED_W{1'b1}})) begin
				out_d.median_depth = '1;
			end else begin
				out_d.median_depth = rmmd_pkg::MED_W'(scaled);
			end
			if (cnt_ext > rmmd_pkg::CNTX_W'({rmmd_pkg::SEEN_W{1'b1}})) begin
				out_d.rows_seen = '1;
			end else begin
				out_d.rows_seen = rmmd_pkg::SEEN_W'(cnt_ext);
			end
		end
	end

	// row and box state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_min_q     <= '0;
			row_started_q <= 1'b0;
			count_q       <= '0;
			ovf_q         <= 1'b0;
		end else if (pix_acc) begin
			if (pixel.row_last || pixel.box_last) begin
				row_min_q     <= '0;
				row_started_q <= 1'b0;
			end else begin
				row_min_q     <= cur_min;
				row_started_q <= 1'b1;
			end
			if (pixel.box_last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (ins) begin
					count_q <= count_q + 1'b1;
				end
				if (pixel.row_last && full) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// result pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			valid_s1 <= pix_acc & pixel.box_last;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				valid_s3 <= 1'b1;
			end else if (out_adv) begin
				valid_s3 <= 1'b0;
			end
			if (out_adv) begin
				result_valid_q <= valid_s3;
			end
		end
	end

	// result pipeline data
	always_ff @(posedge clk) begin
		if (pix_acc && pixel.box_last) begin
			cnt_s1 <= ins ? count_q + 1'b1 : count_q;
			ovf_s1 <= ovf_q | (pixel.row_last & full);
		end
		if (valid_s1) begin
			cnt_s2 <= cnt_s1;
			ovf_s2 <= ovf_s1;
			grp_s2 <= grp_d;
		end
		if (valid_s2) begin
			cnt_s3 <= cnt_s2;
			ovf_s3 <= ovf_s2;
			med_s3 <= med_d;
		end
		if (out_adv && valid_s3) begin
			result_q <= out_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`include "assert_macros.svh"

	`CHECK_CLK(a_one_box_in_flight, $onehot0({valid_s1, valid_s2, valid_s3}), "two boxes in flight")
	`CHECK_CLK(a_count_in_range, count_q <= rmmd_pkg::CNT_W'(rmmd_pkg::MAX_ROWS), "row count past store")
	`CHECK_NEXT(a_box_clears, pix_acc && pixel.box_last, count_q == '0 && !ovf_q, "box state not cleared")
	`CHECK_IMPL(a_empty_result, result_valid && result.empty_box, result.rows_seen == '0 && result.median_depth == '0, "empty box result not zero")

endmodule

>>> sim/row_median_checker.sv
// ----------------------------------------------------------------------------
// row_median_checker
// Watches both channels of the row minimum median depth block, predicts each
// box result from the accepted pixels and compares it field by field.
// ----------------------------------------------------------------------------
module row_median_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pixel_valid,
	input  logic                pixel_stall,
	input  rmmd_pkg::rmmd_in_t  pixel,
	input  logic                result_valid,
	input  logic                result_stall,
	input  rmmd_pkg::rmmd_out_t result,
	output int                  pending,
	output int                  mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [rmmd_pkg::DEPTH_W-1:0] run_min;
	logic                         row_open;
	logic                         dropped_row;
	logic [rmmd_pkg::DEPTH_W-1:0] minima_sorted[$];
	rmmd_pkg::rmmd_out_t          medians_due[$];
	int                           fail_count = 0;

	task automatic take_pixel(input rmmd_pkg::rmmd_in_t px);
		rmmd_pkg::rmmd_out_t med;
		logic [63:0]         scaled;
		int                  slot;
		if (!row_open || px.depth_sample < run_min) begin
			run_min = px.depth_sample;
		end
		row_open = 1'b1;
		if (px.row_last) begin
			if (minima_sorted.size() >= rmmd_pkg::MAX_ROWS) begin
				dropped_row = 1'b1;
			end else begin
				// equal minima go after the stored ones
				slot = minima_sorted.size();
				while (slot > 0 && minima_sorted[slot-1] > run_min) slot--;
				minima_sorted.insert(slot, run_min);
			end
			row_open = 1'b0;
			run_min  = '0;
		end
		if (px.box_last) begin
			med = '0;
			if (minima_sorted.size() == 0) begin
				med.empty_box = 1'b1;
			end else begin
				scaled = (64'(minima_sorted[minima_sorted.size() / 2]) *
					64'(rmmd_pkg::DEPTH_SCALE)) >> rmmd_pkg::DEPTH_FRAC_BITS;
				med.median_depth = (scaled > {rmmd_pkg::MED_W{1'b1}}) ?
					{rmmd_pkg::MED_W{1'b1}} : scaled[rmmd_pkg::MED_W-1:0];
				med.rows_seen = (minima_sorted.size() > {rmmd_pkg::SEEN_W{1'b1}}) ?
					{rmmd_pkg::SEEN_W{1'b1}} : rmmd_pkg::SEEN_W'(minima_sorted.size());
			end
			med.rows_overflow = dropped_row;
			medians_due.insert(medians_due.size(), med);
			minima_sorted.delete();
			dropped_row = 1'b0;
			row_open    = 1'b0;
			run_min     = '0;
		end
	endtask

	task automatic compare_field(input string name,
		input logic [rmmd_pkg::MED_W-1:0] want, input logic [rmmd_pkg::MED_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result(input rmmd_pkg::rmmd_out_t got);
		rmmd_pkg::rmmd_out_t want;
		if (medians_due.size() == 0) begin
			$error("result with none expected: median_depth %0d rows_seen %0d",
				got.median_depth, got.rows_seen);
			fail_count++;
		end else begin
			want = medians_due.pop_front();
			compare_field("median_depth", want.median_depth, got.median_depth);
			compare_field("rows_seen", rmmd_pkg::MED_W'(want.rows_seen),
				rmmd_pkg::MED_W'(got.rows_seen));
			compare_field("empty_box", rmmd_pkg::MED_W'(want.empty_box),
				rmmd_pkg::MED_W'(got.empty_box));
			compare_field("rows_overflow", rmmd_pkg::MED_W'(want.rows_overflow),
				rmmd_pkg::MED_W'(got.rows_overflow));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min     = '0;
			row_open    = 1'b0;
			dropped_row = 1'b0;
			minima_sorted.delete();
			medians_due.delete();
			pending    <= 0;
			mismatches <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				check_result(result);
			end
			if (pixel_valid && !pixel_stall) begin
				take_pixel(pixel);
			end
			pending    <= medians_due.size();
			mismatches <= fail_count;
		end
	end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams depth boxes into the row minimum median depth block: a directed
// set of corner boxes, then random boxes, noise and overflowing boxes under
// three idle and stall mixes. The checker beside the block scores results.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {BOX_CLOSED_ROW, BOX_OPEN_ROW} box_end_t;
	typedef enum int {MIX_FULL, MIX_TIES, MIX_EDGES} depth_mix_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                pixel_valid = 1'b0;
	logic                pixel_stall;
	rmmd_pkg::rmmd_in_t  pixel = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	rmmd_pkg::rmmd_out_t result;
	int                  pending;
	int                  mismatches;
	int                  idle_pct = 9;
	int                  stall_pct = 74;
	int                  sent = 0;
	logic                burst = 1'b0;

	row_minimum_median_depth DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	row_median_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.pending      (pending),
		.mismatches   (mismatches)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic logic [rmmd_pkg::DEPTH_W-1:0] pick_depth(input depth_mix_t mix);
		case (mix)
			MIX_TIES:  return rmmd_pkg::DEPTH_W'($urandom_range(7));
			MIX_EDGES: return $urandom_range(1) ? {rmmd_pkg::DEPTH_W{1'b1}} :
				{rmmd_pkg::DEPTH_W{1'b0}};
			default:   return $urandom();
		endcase
	endfunction

	// one request per call, held until accepted
	task automatic send_pixel(input logic [rmmd_pkg::DEPTH_W-1:0] depth,
		input logic row_end, input logic box_end);
		while (!burst && $urandom_range(99) < idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel       <= '{depth_sample: depth, row_last: row_end, box_last: box_end};
		pixel_valid <= 1'b1;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		sent++;
	endtask

	task automatic send_box(input int rows, input int len_max, input box_end_t ending,
		input depth_mix_t mix);
		int len;
		for (int r = 0; r < rows; r++) begin
			len = $urandom_range(1, len_max);
			for (int p = 0; p < len; p++) begin
				send_pixel(pick_depth(mix), p == len - 1,
					ending == BOX_CLOSED_ROW && r == rows - 1 && p == len - 1);
			end
		end
		if (ending == BOX_OPEN_ROW || rows == 0) begin
			len = $urandom_range(1, len_max);
			for (int p = 0; p < len; p++) begin
				send_pixel(pick_depth(mix), 1'b0, p == len - 1);
			end
		end
	endtask

	task automatic wait_results();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic run_random(input int goal);
		box_end_t   ending;
		depth_mix_t mix;
		while (sent < goal) begin
			burst  = ($urandom_range(7) == 0);
			ending = ($urandom_range(3) == 0) ? BOX_OPEN_ROW : BOX_CLOSED_ROW;
			case ($urandom_range(2))
				0:       mix = MIX_TIES;
				1:       mix = MIX_EDGES;
				default: mix = MIX_FULL;
			endcase
			if ($urandom_range(99) < 8) begin
				// flags at random
				repeat ($urandom_range(1, 6)) begin
					send_pixel($urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)));
				end
			end else begin
				send_box($urandom_range(0, 8), $urandom_range(1, 6), ending, mix);
			end
		end
		burst = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one full-scale pixel closes its row and the box
		send_pixel({rmmd_pkg::DEPTH_W{1'b1}}, 1'b1, 1'b1);
		// empty box
		send_pixel(32'h1234_5678, 1'b0, 1'b1);
		// equal minima, then a partial row dropped at box end
		send_pixel(32'h0001_0000, 1'b0, 1'b0);
		send_pixel(32'd3, 1'b0, 1'b0);
		send_pixel(32'd9, 1'b1, 1'b0);
		send_pixel(32'd3, 1'b1, 1'b0);
		send_pixel(32'd7, 1'b0, 1'b0);
		send_pixel({rmmd_pkg::DEPTH_W{1'b1}}, 1'b1, 1'b0);
		send_pixel(32'd0, 1'b0, 1'b1);
		// zero and full scale, median at the top
		send_pixel({rmmd_pkg::DEPTH_W{1'b1}}, 1'b1, 1'b0);
		send_pixel({rmmd_pkg::DEPTH_W{1'b1}}, 1'b0, 1'b0);
		send_pixel(32'd0, 1'b1, 1'b1);
		// falling minima insert at the front
		send_pixel(32'd40, 1'b1, 1'b0);
		send_pixel(32'd30, 1'b1, 1'b0);
		send_pixel(32'd20, 1'b1, 1'b0);
		send_pixel(32'd10, 1'b1, 1'b1);
		// box end on the first pixel of a new row
		send_pixel(32'd1, 1'b1, 1'b0);
		send_pixel(32'd2, 1'b1, 1'b0);
		send_pixel(32'd5, 1'b0, 1'b1);

		// store overflow, rows closed by the box end
		send_box(rmmd_pkg::MAX_ROWS + 4 + $urandom_range(8), 1, BOX_CLOSED_ROW, MIX_FULL);
		run_random(480);
		wait_results();

		idle_pct  = 74;
		stall_pct = 9;
		send_pixel($urandom(), 1'b0, 1'b1);
		send_box(rmmd_pkg::MAX_ROWS + 2, 2, BOX_OPEN_ROW, MIX_TIES);
		run_random(940);
		wait_results();

		idle_pct  = 0;
		stall_pct = 0;
		send_pixel($urandom(), 1'b0, 1'b1);
		// store exactly full
		send_box(rmmd_pkg::MAX_ROWS, 1, BOX_CLOSED_ROW, MIX_FULL);
		run_random(1400);
		wait_results();

		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
